// ----- rtl/alpha_beta_range_filter_unit_defines.svh -----
`ifndef ALPHA_BETA_RANGE_FILTER_UNIT_DEFINES_SVH
`define ALPHA_BETA_RANGE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define ABRF_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ABRF_ASSERT_NXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/abrf_pkg.sv -----
package abrf_pkg;

  localparam int DATA_W    = 32;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam int TICKS_PER_SECOND = 1000000;

  localparam int OP_A_W = DATA_W + TIME_W;
  localparam int OP_B_W = DATA_W + TIME_W;
  localparam int PROD_W = OP_A_W + OP_B_W;
  localparam int SUM_W  = DATA_W + TIME_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int MUL_STEPS = OP_B_W;
  localparam int DIV_STEPS = PROD_W;

  // rate * dt / ticks as (rate * dt * RECIP) >> RECIP_SHIFT, exact over the full product range
  localparam int RECIP_SHIFT = DATA_W - 1 + TIME_W + $clog2(TICKS_PER_SECOND);
  localparam logic [PROD_W-1:0] RECIP_FULL =
    ((PROD_W'(1) << RECIP_SHIFT) + PROD_W'(TICKS_PER_SECOND - 1)) / PROD_W'(TICKS_PER_SECOND);
  localparam logic [OP_B_W-1:0] RECIP = RECIP_FULL[OP_B_W-1:0];

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_GATE  = CFG_IDX_W'(4);

  localparam logic [GAIN_W-1:0] ALPHA_RESET = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0] BETA_RESET  = GAIN_W'(655);
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [OP_B_W-1:0] TICKS_B = OP_B_W'(TICKS_PER_SECOND);

  typedef struct packed {
    logic              start;
    logic              divide;
    logic [OP_A_W-1:0] a;
    logic [OP_B_W-1:0] b;
    logic [TIME_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } md_resp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] filtered;
    logic signed [DATA_W-1:0] rate;
    logic                     first;
  } abrf_result_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PRED,
    CS_SCALE,
    CS_RES,
    CS_ALPHA,
    CS_BETA,
    CS_RATE,
    CS_FINISH
  } core_state_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-DATA_W){1'b0}}, DATA_MAX};
    lo = {{(SUM_W-DATA_W){1'b1}}, DATA_MIN};
    if (x > hi) begin
      return DATA_MAX;
    end else if (x < lo) begin
      return DATA_MIN;
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/abrf_muldiv.sv -----
module abrf_muldiv
  import abrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  md_req_t  req,
  output md_resp_t resp
);

  md_state_t         state;
  md_state_t         state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_next;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] rem_next;
  logic [OP_A_W-1:0] a_r;
  logic [TIME_W-1:0] d_r;
  logic              div_r;
  logic              done;
  logic              done_next;

  logic [OP_A_W:0]   mul_sum;
  logic [TIME_W:0]   rem_sh;
  logic              ge;

  assign mul_sum = {1'b0, acc[PROD_W-1:OP_B_W]} + {1'b0, (acc[0] ? a_r : '0)};
  assign rem_sh  = {rem, acc[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, d_r};

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    acc_next   = acc;
    rem_next   = rem;
    done_next  = 1'b0;
    unique case (state)
      MD_IDLE: begin
        if (req.start) begin
          acc_next   = {{OP_A_W{1'b0}}, req.b};
          rem_next   = '0;
          cnt_next   = '0;
          state_next = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_next = {mul_sum, acc[OP_B_W-1:1]};
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cnt_next = '0;
          if (div_r) begin
            state_next = MD_DIV;
          end else begin
            state_next = MD_IDLE;
            done_next  = 1'b1;
          end
        end
      end
      MD_DIV: begin
        acc_next = {acc[PROD_W-2:0], ge};
        rem_next = ge ? TIME_W'(rem_sh - {1'b0, d_r}) : rem_sh[TIME_W-1:0];
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = MD_IDLE;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    rem <= rem_next;
    if (state == MD_IDLE && req.start) begin
      a_r   <= req.a;
      d_r   <= req.d;
      div_r <= req.divide;
    end
  end

  assign resp.done   = done;
  assign resp.result = acc;

endmodule

// ----- rtl/abrf_core.sv -----
module abrf_core
  import abrf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic [TIME_W-1:0]        sample_time,
  input  logic [GAIN_W-1:0]        alpha_gain,
  input  logic [GAIN_W-1:0]        beta_gain,
  input  logic                     take,
  output abrf_result_t             result
);

  core_state_t state;
  core_state_t state_next;

  logic signed [DATA_W-1:0] estimate;
  logic signed [DATA_W-1:0] rate;
  logic [TIME_W-1:0]        last_time;
  logic signed [DATA_W-1:0] z_r;
  logic [TIME_W-1:0]        dt_r;
  logic signed [DATA_W-1:0] pred_r;
  logic [DATA_W:0]          res_mag_r;
  logic                     res_neg_r;
  logic                     first_r;

  md_req_t  md_req;
  md_resp_t md_resp;

  logic                     accept;
  logic                     zero_state;
  logic [TIME_W-1:0]        dt_raw;
  logic [TIME_W-1:0]        dt_sel;
  logic [DATA_W-1:0]        rate_mag;
  logic signed [DATA_W:0]   res_new;
  logic [DATA_W:0]          res_mag;
  logic signed [SUM_W-1:0]  est_ext;
  logic signed [SUM_W-1:0]  rate_ext;
  logic signed [SUM_W-1:0]  pred_ext;
  logic signed [SUM_W-1:0]  pred_q_ext;
  logic signed [SUM_W-1:0]  q_ext;
  logic signed [SUM_W-1:0]  scaled_ext;
  logic signed [SUM_W-1:0]  pred_sum;
  logic signed [SUM_W-1:0]  est_sum;
  logic signed [SUM_W-1:0]  rate_sum;

  abrf_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .resp (md_resp)
  );

  assign accept     = in_valid && in_ready;
  assign zero_state = (estimate == '0) && (rate == '0);
  assign dt_raw     = sample_time - last_time;
  assign dt_sel     = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
  assign rate_mag   = rate[DATA_W-1] ? (~rate + DATA_W'(1)) : rate;
  assign res_new    = {z_r[DATA_W-1], z_r} - {pred_r[DATA_W-1], pred_r};
  assign res_mag    = res_new[DATA_W] ? (~res_new + (DATA_W+1)'(1)) : res_new;

  assign est_ext    = {{(SUM_W-DATA_W){estimate[DATA_W-1]}}, estimate};
  assign rate_ext   = {{(SUM_W-DATA_W){rate[DATA_W-1]}}, rate};
  assign pred_ext   = {{(SUM_W-DATA_W){pred_r[DATA_W-1]}}, pred_r};
  assign pred_q_ext = {{(SUM_W-PROD_W+RECIP_SHIFT){1'b0}},
                       md_resp.result[PROD_W-1:RECIP_SHIFT]};
  assign q_ext      = {1'b0, md_resp.result[SUM_W-2:0]};
  assign scaled_ext = {{(FRAC_BITS+1){1'b0}}, md_resp.result[SUM_W-2:FRAC_BITS]};
  assign pred_sum   = est_ext + (rate[DATA_W-1] ? -pred_q_ext : pred_q_ext);
  assign est_sum    = pred_ext + (res_neg_r ? -scaled_ext : scaled_ext);
  assign rate_sum   = rate_ext + (res_neg_r ? -q_ext : q_ext);

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    result.valid    = 1'b0;
    result.filtered = estimate;
    result.rate     = rate;
    result.first    = first_r;
    md_req.start    = 1'b0;
    md_req.divide   = 1'b0;
    md_req.a        = '0;
    md_req.b        = '0;
    md_req.d        = '0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (zero_state) begin
            state_next = CS_FINISH;
          end else begin
            md_req.start = 1'b1;
            md_req.a     = {{(OP_A_W-DATA_W){1'b0}}, rate_mag};
            md_req.b     = {{(OP_B_W-TIME_W){1'b0}}, dt_sel};
            state_next   = CS_PRED;
          end
        end
      end
      CS_PRED: begin
        if (md_resp.done) begin
          md_req.start = 1'b1;
          md_req.a     = md_resp.result[OP_A_W-1:0];
          md_req.b     = RECIP;
          state_next   = CS_SCALE;
        end
      end
      CS_SCALE: begin
        if (md_resp.done) begin
          state_next = CS_RES;
        end
      end
      CS_RES: begin
        md_req.start = 1'b1;
        md_req.a     = {{(OP_A_W-DATA_W-1){1'b0}}, res_mag};
        md_req.b     = {{(OP_B_W-GAIN_W){1'b0}}, alpha_gain};
        state_next   = CS_ALPHA;
      end
      CS_ALPHA: begin
        if (md_resp.done) begin
          md_req.start = 1'b1;
          md_req.a     = {{(OP_A_W-DATA_W-1){1'b0}}, res_mag_r};
          md_req.b     = {{(OP_B_W-GAIN_W){1'b0}}, beta_gain};
          state_next   = CS_BETA;
        end
      end
      CS_BETA: begin
        if (md_resp.done) begin
          md_req.start  = 1'b1;
          md_req.divide = 1'b1;
          md_req.a      = md_resp.result[OP_A_W+FRAC_BITS-1:FRAC_BITS];
          md_req.b      = TICKS_B;
          md_req.d      = dt_r;
          state_next    = CS_RATE;
        end
      end
      CS_RATE: begin
        if (md_resp.done) begin
          state_next = CS_FINISH;
        end
      end
      CS_FINISH: begin
        result.valid = 1'b1;
        if (take) begin
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate  <= '0;
      rate      <= '0;
      last_time <= '0;
      first_r   <= 1'b0;
    end else begin
      case (state)
        CS_IDLE: begin
          if (accept) begin
            last_time <= sample_time;
            z_r       <= sample_value;
            dt_r      <= dt_sel;
            first_r   <= zero_state;
            if (zero_state) begin
              estimate <= sample_value;
            end
          end
        end
        CS_SCALE: begin
          if (md_resp.done) begin
            pred_r <= sat_data(pred_sum);
          end
        end
        CS_RES: begin
          res_mag_r <= res_mag;
          res_neg_r <= res_new[DATA_W];
        end
        CS_ALPHA: begin
          if (md_resp.done) begin
            estimate <= sat_data(est_sum);
          end
        end
        CS_RATE: begin
          if (md_resp.done) begin
            rate <= sat_data(rate_sum);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/alpha_beta_range_filter_unit.sv -----
// Alpha-beta tracker for one timestamped sensor value (Q15.16, gains Q1.16).
// Input channel: in_valid/in_ready carries sample_value and sample_time.
// Output channel: out_valid/out_ready carries filtered_value, rate_value,
// in_range and first_sample; exactly one result transaction per input.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// in the same cycle (0 alpha, 1 beta, 2 lower, 3 upper, 4 gate); other
// indexes are ignored. Write only while the block is idle.
// An initializing sample (estimate and rate both zero) skips the multiply/divide
// unit and goes straight to the finishing state. For a tracking sample,
// the shared bit-serial multiply/divide unit runs five jobs in turn, each
// 64 multiply steps, the last followed by 128 divide steps. One sample is in
// work at a time; in_ready is high only between samples, so a new sample
// waits until the previous one is done.
// The result sits in an output register, so the next sample is accepted
// while it waits; if the receiver still stalls when that sample finishes,
// the block holds it and stays not ready until the register frees.
// Reset loads the default gains and limits and clears estimate, rate and
// last time stamp, so the first sample after reset initializes.
`include "alpha_beta_range_filter_unit_defines.svh"

module alpha_beta_range_filter_unit
  import abrf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic [TIME_W-1:0]        sample_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] filtered_value,
  output logic signed [DATA_W-1:0] rate_value,
  output logic                     in_range,
  output logic                     first_sample
);

  logic [GAIN_W-1:0]        alpha_gain;
  logic [GAIN_W-1:0]        beta_gain;
  logic signed [DATA_W-1:0] lower_limit;
  logic signed [DATA_W-1:0] upper_limit;
  logic                     gate_enable;

  abrf_result_t result;
  logic         take;
  logic         load;
  logic         range_ok;

  abrf_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .sample_time  (sample_time),
    .alpha_gain   (alpha_gain),
    .beta_gain    (beta_gain),
    .take         (take),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain  <= ALPHA_RESET;
      beta_gain   <= BETA_RESET;
      lower_limit <= '0;
      upper_limit <= DATA_MAX;
      gate_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_gain  <= cfg_data[GAIN_W-1:0];
        CFG_BETA:  beta_gain   <= cfg_data[GAIN_W-1:0];
        CFG_LOWER: lower_limit <= cfg_data;
        CFG_UPPER: upper_limit <= cfg_data;
        CFG_GATE:  gate_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign take     = !out_valid || out_ready;
  assign load     = result.valid && take;
  assign range_ok = !gate_enable ||
                    ((result.filtered >= lower_limit) && (result.filtered <= upper_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered_value <= result.filtered;
      rate_value     <= result.rate;
      in_range       <= range_ok;
      first_sample   <= result.first;
    end
  end

  `ABRF_ASSERT_IMP(a_ready_no_pending, clk, rst, in_ready, !result.valid, "ready with result")
  `ABRF_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `ABRF_ASSERT_NXT(a_load_shows, clk, rst, load, out_valid, "loaded result not shown")
  `ABRF_ASSERT_NXT(a_result_held, clk, rst, result.valid && !take, result.valid, "result dropped")

endmodule
